/* rtl/core/vortex_pair_velocity_accumulator_core_defines.svh */
// Assertion macros for the vortex pair velocity accumulator core.
// Each use expects clk and arst_n in scope.
`ifndef VORTEX_PAIR_VELOCITY_ACCUMULATOR_CORE_DEFINES_SVH
`define VORTEX_PAIR_VELOCITY_ACCUMULATOR_CORE_DEFINES_SVH

`define VPVA_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`define VPVA_ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

/* rtl/core/vpva_pkg.sv */
`timescale 1ns / 1ps
package vpva_pkg;

	localparam int FRAC_BITS = 32;

	typedef struct packed {
		logic first;
		logic last;
		logic neg_u;
		logic neg_v;
	} vpva_flags_t;

	localparam int FLAG_BITS = 4;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_MUL,
		BK_DIV,
		BK_ACC
	} bk_state_t;

	localparam logic [2:0] MS_DXX = 3'd0;
	localparam logic [2:0] MS_DYY = 3'd1;
	localparam logic [2:0] MS_RR  = 3'd2;
	localparam logic [2:0] MS_SDY = 3'd3;
	localparam logic [2:0] MS_SDX = 3'd4;
	localparam logic [2:0] MS_FIN = 3'd5;

endpackage

/* rtl/core/vpva_front.sv */
`timescale 1ns / 1ps
module vpva_front #(
	parameter int COORD_BITS = 24
) (
	input  logic signed [COORD_BITS-1:0] source_x,
	input  logic signed [COORD_BITS-1:0] source_y,
	input  logic signed [COORD_BITS-1:0] source_strength,
	input  logic signed [COORD_BITS-1:0] target_x,
	input  logic signed [COORD_BITS-1:0] target_y,
	input  logic                         first_source,
	input  logic                         last_source,
	output logic [COORD_BITS-1:0]        mag_dx,
	output logic [COORD_BITS-1:0]        mag_dy,
	output logic [COORD_BITS-1:0]        mag_str,
	output vpva_pkg::vpva_flags_t        flags
);
	import vpva_pkg::*;

	logic signed [COORD_BITS:0] dx;
	logic signed [COORD_BITS:0] dy;
	logic signed [COORD_BITS:0] str_x;
	logic signed [COORD_BITS:0] ndx;
	logic signed [COORD_BITS:0] ndy;
	logic signed [COORD_BITS:0] nstr;

	assign dx    = {target_x[COORD_BITS-1], target_x} - {source_x[COORD_BITS-1], source_x};
	assign dy    = {target_y[COORD_BITS-1], target_y} - {source_y[COORD_BITS-1], source_y};
	assign str_x = {source_strength[COORD_BITS-1], source_strength};
	assign ndx   = -dx;
	assign ndy   = -dy;
	assign nstr  = -str_x;

	always_comb begin
		mag_dx      = dx[COORD_BITS] ? ndx[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
		mag_dy      = dy[COORD_BITS] ? ndy[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
		mag_str     = str_x[COORD_BITS] ? nstr[COORD_BITS-1:0] : str_x[COORD_BITS-1:0];
		flags.first = first_source;
		flags.last  = last_source;
		flags.neg_u = !(str_x[COORD_BITS] ^ dy[COORD_BITS]);
		flags.neg_v = str_x[COORD_BITS] ^ dx[COORD_BITS];
	end

endmodule

/* rtl/core/vpva_fifo.sv */
`timescale 1ns / 1ps
`include "vortex_pair_velocity_accumulator_core_defines.svh"
module vpva_fifo #(
	parameter int WIDTH = 99
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty
);
	import vpva_pkg::*;

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             do_push;
	logic             do_pop;

	assign full     = count_q == 2'd2;
	assign empty    = count_q == 2'd0;
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push)
				wr_ptr_q <= !wr_ptr_q;
			if (do_pop)
				rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_data;
	end

	`VPVA_ASSERT_NEVER(a_count_range, count_q == 2'd3, "fifo count out of range")
	`VPVA_ASSERT_NEVER(a_pop_empty, pop && empty, "pop from empty fifo")
	`VPVA_ASSERT_IMPLIES(a_ptr_track, count_q == 2'd0 || count_q == 2'd2, wr_ptr_q == rd_ptr_q, "fifo pointers disagree with count")

endmodule

/* rtl/core/vpva_back.sv */
`timescale 1ns / 1ps
module vpva_back #(
	parameter int COORD_BITS = 24,
	parameter int ACC_BITS   = 48
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         empty,
	output logic                         pop,
	input  logic [COORD_BITS-1:0]        in_dx,
	input  logic [COORD_BITS-1:0]        in_dy,
	input  logic [COORD_BITS-2:0]        in_rad,
	input  logic [COORD_BITS-1:0]        in_str,
	input  vpva_pkg::vpva_flags_t        in_flags,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [ACC_BITS-1:0]   vel_u,
	output logic signed [ACC_BITS-1:0]   vel_v,
	output logic                         saturated
);
	import vpva_pkg::*;

	localparam int PW  = 2 * COORD_BITS - 1;
	localparam int DW  = 2 * COORD_BITS + 2;
	localparam int RW  = DW + 1;
	localparam int QW  = PW + FRAC_BITS;
	localparam int QX  = (QW > ACC_BITS) ? QW : ACC_BITS + 1;
	localparam int DCW = $clog2(QW + 1);

	bk_state_t state_q, state_d;

	logic [COORD_BITS-1:0]   adx_q, ady_q, asm_q;
	logic [COORD_BITS-2:0]   rad_q;
	vpva_flags_t             flags_q;
	logic [2:0]              mul_cnt_q;
	logic [DCW-1:0]          div_cnt_q;
	logic [2*COORD_BITS-1:0] prod_q;
	logic [DW-1:0]           d_q;
	logic [QW-1:0]           nu_q, nv_q;
	logic [RW-1:0]           rem_u_q, rem_v_q;
	logic signed [ACC_BITS-1:0] sum_u_q, sum_v_q;
	logic                    sat_q;
	logic                    out_valid_q;
	logic signed [ACC_BITS-1:0] vel_u_q, vel_v_q;
	logic                    sat_out_q;

	logic [COORD_BITS-1:0]   ma, mb;
	logic [2*COORD_BITS-1:0] prod;
	logic [RW-1:0]           rsh_u, rsh_v;
	logic                    ge_u, ge_v;
	logic                    acc_go;
	logic                    mul_done, div_done;
	logic signed [ACC_BITS-1:0] base_u, base_v, new_u, new_v;
	logic                    sat_u, sat_v;

	function automatic logic [ACC_BITS:0] acc_add(
		input logic signed [ACC_BITS-1:0] s,
		input logic [QW-1:0]              q,
		input logic                       neg,
		input logic                       zero
	);
		logic [QX-1:0]              qx;
		logic                       big;
		logic signed [ACC_BITS+1:0] t;
		logic signed [ACC_BITS+1:0] m;
		logic                       ovf;
		logic signed [ACC_BITS-1:0] r;
		qx  = zero ? '0 : QX'(q);
		big = |qx[QX-1:ACC_BITS];
		m   = {2'b00, qx[ACC_BITS-1:0]};
		t   = neg ? ({s[ACC_BITS-1], s[ACC_BITS-1], s} - m)
		          : ({s[ACC_BITS-1], s[ACC_BITS-1], s} + m);
		ovf = big || (t[ACC_BITS+1] != t[ACC_BITS]) || (t[ACC_BITS] != t[ACC_BITS-1]);
		if (ovf)
			r = neg ? {1'b1, {(ACC_BITS-1){1'b0}}} : {1'b0, {(ACC_BITS-1){1'b1}}};
		else
			r = t[ACC_BITS-1:0];
		return {ovf, r};
	endfunction

	always_comb begin
		case (mul_cnt_q)
			MS_DXX: begin
				ma = adx_q;
				mb = adx_q;
			end
			MS_DYY: begin
				ma = ady_q;
				mb = ady_q;
			end
			MS_RR: begin
				ma = {1'b0, rad_q};
				mb = {1'b0, rad_q};
			end
			MS_SDY: begin
				ma = asm_q;
				mb = ady_q;
			end
			MS_SDX: begin
				ma = asm_q;
				mb = adx_q;
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	assign prod     = ma * mb;
	assign mul_done = mul_cnt_q == MS_FIN;
	assign div_done = div_cnt_q == DCW'(QW - 1);

	assign rsh_u = {rem_u_q[RW-2:0], nu_q[QW-1]};
	assign rsh_v = {rem_v_q[RW-2:0], nv_q[QW-1]};
	assign ge_u  = rsh_u >= {1'b0, d_q};
	assign ge_v  = rsh_v >= {1'b0, d_q};

	assign base_u = flags_q.first ? '0 : sum_u_q;
	assign base_v = flags_q.first ? '0 : sum_v_q;
	assign {sat_u, new_u} = acc_add(base_u, nu_q, flags_q.neg_u, d_q == '0);
	assign {sat_v, new_v} = acc_add(base_v, nv_q, flags_q.neg_v, d_q == '0);

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: if (!empty) state_d = BK_MUL;
			BK_MUL: if (mul_done) state_d = (d_q != '0) ? BK_DIV : BK_ACC;
			BK_DIV: if (div_done) state_d = BK_ACC;
			BK_ACC: if (acc_go) state_d = BK_IDLE;
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		pop    = 1'b0;
		acc_go = 1'b0;
		case (state_q)
			BK_IDLE: pop = !empty;
			BK_ACC: acc_go = !flags_q.last || !out_valid_q || !out_stall;
			default: begin
				pop    = 1'b0;
				acc_go = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			mul_cnt_q   <= MS_DXX;
			div_cnt_q   <= '0;
			sum_u_q     <= '0;
			sum_v_q     <= '0;
			sat_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_valid_q && !out_stall && !(state_q == BK_ACC && acc_go && flags_q.last))
				out_valid_q <= 1'b0;
			case (state_q)
				BK_IDLE: mul_cnt_q <= MS_DXX;
				BK_MUL: begin
					mul_cnt_q <= mul_cnt_q + 3'd1;
					div_cnt_q <= '0;
				end
				BK_DIV: div_cnt_q <= div_cnt_q + DCW'(1);
				BK_ACC: if (acc_go) begin
					sum_u_q <= new_u;
					sum_v_q <= new_v;
					sat_q   <= (sat_q && !flags_q.first) || sat_u || sat_v;
					if (flags_q.last)
						out_valid_q <= 1'b1;
				end
				default: mul_cnt_q <= MS_DXX;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			adx_q   <= in_dx;
			ady_q   <= in_dy;
			rad_q   <= in_rad;
			asm_q   <= in_str;
			flags_q <= in_flags;
		end
		if (state_q == BK_MUL) begin
			prod_q <= prod;
			case (mul_cnt_q)
				MS_DXX: d_q <= '0;
				MS_DYY, MS_RR, MS_SDY: d_q <= d_q + DW'(prod_q);
				MS_SDX: nu_q <= {prod_q[PW-1:0], {FRAC_BITS{1'b0}}};
				MS_FIN: begin
					nv_q    <= {prod_q[PW-1:0], {FRAC_BITS{1'b0}}};
					rem_u_q <= '0;
					rem_v_q <= '0;
				end
				default: d_q <= d_q;
			endcase
		end
		if (state_q == BK_DIV) begin
			rem_u_q <= ge_u ? rsh_u - {1'b0, d_q} : rsh_u;
			rem_v_q <= ge_v ? rsh_v - {1'b0, d_q} : rsh_v;
			nu_q    <= {nu_q[QW-2:0], ge_u};
			nv_q    <= {nv_q[QW-2:0], ge_v};
		end
		if (state_q == BK_ACC && acc_go && flags_q.last) begin
			vel_u_q   <= new_u;
			vel_v_q   <= new_v;
			sat_out_q <= (sat_q && !flags_q.first) || sat_u || sat_v;
		end
	end

	assign out_valid = out_valid_q;
	assign vel_u     = vel_u_q;
	assign vel_v     = vel_v_q;
	assign saturated = sat_out_q;

endmodule

/* rtl/core/vortex_pair_velocity_accumulator_core.sv */
// Regularized 2-D vortex velocity accumulator.
// Input channel (in_valid / in_stall): one source-target pair per word, with
// first_source clearing the running sums and last_source requesting a result.
// Output channel (out_valid / out_stall): one word per last_source pair,
// carrying the saturating Q16.32 sums vel_u, vel_v and the saturated flag.
// A two-word queue parts the input side from the arithmetic back end, so
// up to two pairs are taken while the back end is busy.
// Each pair passes in the back end through an issue step, the shared
// multiplier, the restoring divider at one quotient bit per cycle, and an
// accumulate step; the back end takes a new pair only after it has
// finished accumulating the previous one.
// A zero denominator skips the divider and adds nothing.
// Reset empties the queue, clears the sums and the saturation flag, and
// drops any pending result. While the receiver stalls, the result word
// holds; a following pair with last_source waits in the accumulate step.
`timescale 1ns / 1ps
module vortex_pair_velocity_accumulator_core #(
	parameter int COORD_BITS = 24,
	parameter int ACC_BITS   = 48
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [COORD_BITS-1:0] source_x,
	input  logic signed [COORD_BITS-1:0] source_y,
	input  logic [COORD_BITS-2:0]        source_radius,
	input  logic signed [COORD_BITS-1:0] source_strength,
	input  logic signed [COORD_BITS-1:0] target_x,
	input  logic signed [COORD_BITS-1:0] target_y,
	input  logic                         first_source,
	input  logic                         last_source,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [ACC_BITS-1:0]   vel_u,
	output logic signed [ACC_BITS-1:0]   vel_v,
	output logic                         saturated
);
	import vpva_pkg::*;

	localparam int QWIDTH = FLAG_BITS + 4 * COORD_BITS - 1;

	logic [COORD_BITS-1:0] f_dx, f_dy, f_str;
	vpva_flags_t           f_flags;
	logic [QWIDTH-1:0]     q_in, q_out;
	logic                  q_full, q_empty, q_pop;
	vpva_flags_t           b_flags;
	logic [COORD_BITS-1:0] b_dx, b_dy, b_str;
	logic [COORD_BITS-2:0] b_rad;

	vpva_front #(.COORD_BITS(COORD_BITS)) u_front (
		.source_x        (source_x),
		.source_y        (source_y),
		.source_strength (source_strength),
		.target_x        (target_x),
		.target_y        (target_y),
		.first_source    (first_source),
		.last_source     (last_source),
		.mag_dx          (f_dx),
		.mag_dy          (f_dy),
		.mag_str         (f_str),
		.flags           (f_flags)
	);

	assign q_in     = {f_flags, f_dx, f_dy, source_radius, f_str};
	assign in_stall = q_full;

	vpva_fifo #(.WIDTH(QWIDTH)) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_valid),
		.push_data (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_out),
		.empty     (q_empty)
	);

	assign {b_flags, b_dx, b_dy, b_rad, b_str} = q_out;

	vpva_back #(.COORD_BITS(COORD_BITS), .ACC_BITS(ACC_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (q_empty),
		.pop       (q_pop),
		.in_dx     (b_dx),
		.in_dy     (b_dy),
		.in_rad    (b_rad),
		.in_str    (b_str),
		.in_flags  (b_flags),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.vel_u     (vel_u),
		.vel_v     (vel_v),
		.saturated (saturated)
	);

endmodule

/* tb/tb_vortex_pair_velocity_accumulator_core.sv */
`timescale 1ns / 1ps
module tb_vortex_pair_velocity_accumulator_core;

	localparam int CB = 24;
	localparam int AB = 48;
	localparam logic [63:0] AMAX  = (64'd1 << AB) - 1;
	localparam logic [63:0] ABIAS = 64'd1 << (AB - 1);
	localparam int STALL_LIMIT = 20000;
	localparam int HOLD_CYCLES = 400;

	typedef struct {
		logic [CB-1:0] sx, sy, rad, str, tx, ty;
		logic first, last;
		bit drain_first;
	} pair_t;

	typedef struct {
		logic [AB-1:0] u, v;
		logic sat;
	} velocity_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic signed [CB-1:0] source_x = '0, source_y = '0, source_strength = '0;
	logic signed [CB-1:0] target_x = '0, target_y = '0;
	logic [CB-2:0] source_radius = '0;
	logic first_source = 0, last_source = 0;
	logic out_valid;
	logic out_stall = 0;
	logic signed [AB-1:0] vel_u, vel_v;
	logic saturated;

	pair_t pair_q[$];
	velocity_t velocity_q[$];
	pair_t cur;
	logic [AB-1:0] acc_u = '0, acc_v = '0;
	bit acc_sat = 0;
	int acc_cnt = 0;
	int err_cnt = 0;
	int hold_cnt = 0;
	bit held = 0;
	int quiet_cnt = 0;

	vortex_pair_velocity_accumulator_core uut (.*);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	function automatic logic [AB-1:0] sat_add(logic [AB-1:0] s, bit neg, logic [127:0] m);
		logic [63:0] b;
		b = ({16'd0, s} + ABIAS) & AMAX;
		if (m == 0)
			return s;
		if (!neg) begin
			if (m > AMAX || m[63:0] > AMAX - b) begin
				b = AMAX;
				acc_sat = 1;
			end else
				b = b + m[63:0];
		end else begin
			if (m > AMAX || m[63:0] > b) begin
				b = 0;
				acc_sat = 1;
			end else
				b = b - m[63:0];
		end
		return AB'((b - ABIAS) & AMAX);
	endfunction

	function automatic logic [63:0] mag(logic signed [63:0] x);
		return x < 0 ? -x : x;
	endfunction

	function automatic void predict_velocity(pair_t p);
		logic signed [63:0] dx, dy, st;
		logic [63:0] adx, ady, ast, rr, d;
		logic [127:0] tu, tv;
		velocity_t r;
		dx = 64'(signed'(p.tx)) - 64'(signed'(p.sx));
		dy = 64'(signed'(p.ty)) - 64'(signed'(p.sy));
		st = 64'(signed'(p.str));
		adx = mag(dx);
		ady = mag(dy);
		ast = mag(st);
		rr = {41'd0, p.rad[CB-2:0]};
		if (p.first) begin
			acc_u = '0;
			acc_v = '0;
			acc_sat = 0;
		end
		d = adx * adx + ady * ady + rr * rr;
		if (d != 0) begin
			tu = ({64'd0, ast * ady} << 32) / {64'd0, d};
			tv = ({64'd0, ast * adx} << 32) / {64'd0, d};
			acc_u = sat_add(acc_u, (st < 0) == (dy < 0), tu);
			acc_v = sat_add(acc_v, (st < 0) != (dx < 0), tv);
		end
		if (p.last) begin
			r.u = acc_u;
			r.v = acc_v;
			r.sat = acc_sat;
			velocity_q.push_back(r);
		end
	endfunction

	function automatic logic [CB-1:0] rnd_coord();
		case ($urandom_range(3))
			0: return CB'($urandom);
			1: return CB'($urandom_range(1 << 19) - (1 << 18));
			2: return CB'($urandom_range(1 << 13) - (1 << 12));
			default: return CB'($urandom_range(64) - 32);
		endcase
	endfunction

	function automatic pair_t mk(logic [CB-1:0] sx, sy, rad, str, tx, ty,
			logic first, last);
		pair_t p;
		p.sx = sx; p.sy = sy; p.rad = rad; p.str = str; p.tx = tx; p.ty = ty;
		p.first = first; p.last = last; p.drain_first = 0;
		return p;
	endfunction

	function automatic pair_t rnd_pair(logic first, last);
		pair_t p;
		p = mk(rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
			rnd_coord(), first, last);
		p.rad[CB-1] = 0;
		if ($urandom_range(9) == 0)
			p.rad = CB'($urandom) & 24'h7FFFFF;
		return p;
	endfunction

	function automatic int tx_pct();
		case ((acc_cnt / 200) % 4)
			1: return 68;
			3: return 14;
			default: return 0;
		endcase
	endfunction

	function automatic int rx_pct();
		case ((acc_cnt / 200) % 4)
			2: return 68;
			3: return 14;
			default: return 0;
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				predict_velocity(cur);
				acc_cnt++;
			end
			if (!in_valid || !in_stall) begin
				if (pair_q.size() > 0 && !(pair_q[0].drain_first && velocity_q.size() > 0)
						&& $urandom_range(99) >= tx_pct()) begin
					cur = pair_q.pop_front();
					source_x <= cur.sx;
					source_y <= cur.sy;
					source_radius <= cur.rad[CB-2:0];
					source_strength <= cur.str;
					target_x <= cur.tx;
					target_y <= cur.ty;
					first_source <= cur.first;
					last_source <= cur.last;
					in_valid <= 1;
				end else
					in_valid <= 0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 0;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			out_stall <= 1;
		end else if (!held && acc_cnt >= 700) begin
			held <= 1;
			hold_cnt <= HOLD_CYCLES;
			out_stall <= 1;
		end else
			out_stall <= $urandom_range(99) < rx_pct();
	end

	always @(posedge clk) begin
		velocity_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (velocity_q.size() == 0) begin
				err_cnt++;
				if (err_cnt <= 10)
					$display("unexpected word: u=%h v=%h sat=%b", vel_u, vel_v, saturated);
			end else begin
				e = velocity_q.pop_front();
				if (vel_u !== e.u || vel_v !== e.v || saturated !== e.sat) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display("mismatch: exp u=%h v=%h sat=%b got u=%h v=%h sat=%b",
							e.u, e.v, e.sat, vel_u, vel_v, saturated);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cnt <= 0;
		else if (arst_n) begin
			if (quiet_cnt >= STALL_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end else
				quiet_cnt <= quiet_cnt + 1;
		end
	end

	initial begin
		pair_t p;
		int n;
		pair_q.push_back(mk(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,
			24'h800000, 24'h800000, 1, 1));
		pair_q.push_back(mk(24'h800000, 24'h800000, 24'h7FFFFF, 24'h800000,
			24'h7FFFFF, 24'h7FFFFF, 1, 1));
		pair_q.push_back(mk(24'h001000, 24'hFFF000, 0, 24'h7FFFFF,
			24'h001000, 24'hFFF000, 1, 1));
		pair_q.push_back(mk(0, 0, 0, 24'h7FFFFF, 1, 0, 1, 0));
		pair_q.push_back(mk(0, 0, 0, 24'h800000, 0, 24'hFFFFFF, 0, 1));
		pair_q.push_back(mk(0, 0, 24'h010000, 24'h010000, 24'h010000, 0, 0, 1));
		pair_q.push_back(mk(0, 0, 24'h010000, 24'h010000, 0, 24'h010000, 1, 0));
		pair_q.push_back(mk(24'h020000, 24'hFE0000, 24'h008000, 24'hFF0000,
			0, 0, 0, 1));
		pair_q.push_back(mk(0, 0, 24'h7FFFFF, 0, 0, 0, 0, 1));
		pair_q.push_back(mk(24'h7FFFFF, 0, 0, 24'h000001, 24'h800000, 0, 1, 1));
		pair_q.push_back(mk(0, 24'h7FFFFF, 0, 24'h800000, 0, 24'h800000, 1, 1));
		pair_q.push_back(mk(5, 7, 3, 24'h000100, 1, 2, 0, 0));
		pair_q.push_back(mk(5, 7, 3, 24'hFFFF00, 9, 2, 0, 1));
		while (pair_q.size() < 2000) begin
			if ($urandom_range(9) == 0) begin
				p = rnd_pair($urandom_range(1), $urandom_range(1));
				pair_q.push_back(p);
			end else begin
				n = $urandom_range(1, 8);
				for (int i = 0; i < n; i++) begin
					p = rnd_pair(i == 0, i == n - 1);
					if (i == 0 && pair_q.size() % 400 < 4)
						p.drain_first = 1;
					pair_q.push_back(p);
				end
			end
		end
		repeat (11) @(posedge clk);
		arst_n <= 1;
		while (pair_q.size() > 0 || in_valid)
			@(posedge clk);
		while (velocity_q.size() > 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		if (err_cnt == 0 && velocity_q.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
